// ===== sv/sha1md_pkg.sv =====
// SHA-1 digest core package: initial hash words, round constants and
// the sequencer state type. Used by sha1_message_digest_core.
// No dependencies.
package sha1md_pkg;

   localparam int LenCountBits = 64;

   localparam int NumHashWords = 5;
   localparam int WindowDepth  = 16;
   localparam int NumRounds    = 80;

   localparam logic [31:0] InitH0 = 32'h67452301;
   localparam logic [31:0] InitH1 = 32'hEFCDAB89;
   localparam logic [31:0] InitH2 = 32'h98BADCFE;
   localparam logic [31:0] InitH3 = 32'h10325476;
   localparam logic [31:0] InitH4 = 32'hC3D2E1F0;

   localparam logic [31:0] RoundK0 = 32'h5A827999;
   localparam logic [31:0] RoundK1 = 32'h6ED9EBA1;
   localparam logic [31:0] RoundK2 = 32'h8F1BBCDC;
   localparam logic [31:0] RoundK3 = 32'hCA62C1D6;

   localparam logic [6:0] RoundStage1 = 7'd20;
   localparam logic [6:0] RoundStage2 = 7'd40;
   localparam logic [6:0] RoundStage3 = 7'd60;
   localparam logic [6:0] RoundLast   = 7'd79;

   localparam logic [31:0] PadMarkerWord = 32'h80000000;
   localparam logic [3:0]  LenHiSlot     = 4'd14;
   localparam logic [3:0]  BlockLastSlot = 4'd15;
   localparam logic [2:0]  DigestLastIdx = 3'd4;
   localparam logic [2:0]  FullWordBytes = 3'd4;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_PAD,
      ST_ROUND,
      ST_FINAL,
      ST_OUT
   } state_type;

endpackage

// ===== sv/sha1_message_digest_core.sv =====
// SHA-1 digest core: word intake, padding sequencer, one shared round
// unit and digest output. Depends on sha1md_pkg.
//
// Usage:
//   Message words enter on the req_ channel, first byte in bits 31..24.
//   A word is taken when req_valid is high and req_stall is low. Words
//   without req_last add four bytes; the word with req_last adds only its
//   leading req_valid_bytes bytes (values above four count as four).
//   Every sixteenth word starts a block: the shared round unit runs all
//   80 rounds, then the result is folded into the chaining words, and
//   req_stall stays high until the fold is done; the other words are
//   taken without a stall. On the last word the padding words are
//   pushed one a cycle except during a block (two to eighteen words, with
//   one or two blocks in all), then the five digest
//   words leave on the rsp_ channel, index 0 first, rsp_last_word on the
//   fifth. A high rsp_stall holds the current digest word unchanged and
//   the core waits; no new message word is taken until the fifth digest
//   word has gone. After reset the core is idle with the initial hash
//   words loaded and ready at once.
module sha1_message_digest_core #(
   parameter int LENGTH_COUNTER_BITS = sha1md_pkg::LenCountBits
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [31:0] req_data_word,
   input  logic [2:0]  req_valid_bytes,
   input  logic        req_last,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [31:0] rsp_digest_word,
   output logic [2:0]  rsp_word_index,
   output logic        rsp_last_word
);

   localparam int CntW = LENGTH_COUNTER_BITS;

   sha1md_pkg::state_type state_ff, state_in;

   logic [31:0]     win_ff [sha1md_pkg::WindowDepth];
   logic [31:0]     win_in [sha1md_pkg::WindowDepth];
   logic [31:0]     h_ff   [sha1md_pkg::NumHashWords];
   logic [31:0]     h_in   [sha1md_pkg::NumHashWords];
   logic [31:0]     v_ff   [sha1md_pkg::NumHashWords];
   logic [31:0]     v_in   [sha1md_pkg::NumHashWords];
   logic [3:0]      wib_ff, wib_in;
   logic [6:0]      rnd_ff, rnd_in;
   logic [CntW-1:0] cnt_ff, cnt_in;
   logic [63:0]     len_ff, len_in;
   logic            pend_ff, pend_in;
   logic            hi_ff, hi_in;
   logic            pad_ff, pad_in;
   logic            done_ff, done_in;
   logic [2:0]      oidx_ff, oidx_in;

   logic        push;
   logic [31:0] push_word;
   logic [2:0]  nb;
   logic [31:0] f_val;
   logic [31:0] k_val;
   logic [31:0] t_val;
   logic [31:0] w_next;
   logic [CntW-1:0] cnt_last;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= sha1md_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         h_ff[0] <= sha1md_pkg::InitH0;
         h_ff[1] <= sha1md_pkg::InitH1;
         h_ff[2] <= sha1md_pkg::InitH2;
         h_ff[3] <= sha1md_pkg::InitH3;
         h_ff[4] <= sha1md_pkg::InitH4;
         for (int i = 0; i < sha1md_pkg::NumHashWords; i++) begin
            v_ff[i] <= '0;
         end
         wib_ff  <= '0;
         rnd_ff  <= '0;
         cnt_ff  <= '0;
         pend_ff <= 1'b0;
         hi_ff   <= 1'b0;
         pad_ff  <= 1'b0;
         done_ff <= 1'b0;
         oidx_ff <= '0;
      end else begin
         h_ff    <= h_in;
         v_ff    <= v_in;
         wib_ff  <= wib_in;
         rnd_ff  <= rnd_in;
         cnt_ff  <= cnt_in;
         pend_ff <= pend_in;
         hi_ff   <= hi_in;
         pad_ff  <= pad_in;
         done_ff <= done_in;
         oidx_ff <= oidx_in;
      end
   end

   always_ff @(posedge clock) begin
      win_ff <= win_in;
      len_ff <= len_in;
   end

   // shared round unit
   always_comb begin
      if (rnd_ff < sha1md_pkg::RoundStage1) begin
         f_val = (v_ff[1] & v_ff[2]) | (~v_ff[1] & v_ff[3]);
         k_val = sha1md_pkg::RoundK0;
      end else if (rnd_ff < sha1md_pkg::RoundStage2) begin
         f_val = v_ff[1] ^ v_ff[2] ^ v_ff[3];
         k_val = sha1md_pkg::RoundK1;
      end else if (rnd_ff < sha1md_pkg::RoundStage3) begin
         f_val = (v_ff[1] & v_ff[2]) | (v_ff[1] & v_ff[3]) | (v_ff[2] & v_ff[3]);
         k_val = sha1md_pkg::RoundK2;
      end else begin
         f_val = v_ff[1] ^ v_ff[2] ^ v_ff[3];
         k_val = sha1md_pkg::RoundK3;
      end
      t_val  = {v_ff[0][26:0], v_ff[0][31:27]} + f_val + v_ff[4] + k_val + win_ff[0];
      w_next = win_ff[13] ^ win_ff[8] ^ win_ff[2] ^ win_ff[0];
      w_next = {w_next[30:0], w_next[31]};
   end

   always_comb begin
      nb       = (req_valid_bytes > sha1md_pkg::FullWordBytes) ?
                 sha1md_pkg::FullWordBytes : req_valid_bytes;
      cnt_last = cnt_ff + CntW'({nb, 3'b000});
   end

   always_comb begin
      state_in  = state_ff;
      win_in    = win_ff;
      h_in      = h_ff;
      v_in      = v_ff;
      wib_in    = wib_ff;
      rnd_in    = rnd_ff;
      cnt_in    = cnt_ff;
      len_in    = len_ff;
      pend_in   = pend_ff;
      hi_in     = hi_ff;
      pad_in    = pad_ff;
      done_in   = done_ff;
      oidx_in   = oidx_ff;
      push      = 1'b0;
      push_word = '0;
      req_stall = 1'b1;
      rsp_valid = 1'b0;

      case (state_ff)
         sha1md_pkg::ST_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               push = 1'b1;
               if (!req_last) begin
                  cnt_in    = cnt_ff + CntW'(32);
                  push_word = req_data_word;
               end else begin
                  cnt_in   = cnt_last;
                  len_in   = 64'(cnt_last);
                  pad_in   = 1'b1;
                  hi_in    = 1'b0;
                  pend_in  = 1'b0;
                  state_in = sha1md_pkg::ST_PAD;
                  case (nb)
                     3'd0: push_word = sha1md_pkg::PadMarkerWord;
                     3'd1: push_word = {req_data_word[31:24], 24'h800000};
                     3'd2: push_word = {req_data_word[31:16], 16'h8000};
                     3'd3: push_word = {req_data_word[31:8], 8'h80};
                     default: begin
                        push_word = req_data_word;
                        pend_in   = 1'b1;
                     end
                  endcase
               end
            end
         end
         sha1md_pkg::ST_PAD: begin
            push = 1'b1;
            if (pend_ff) begin
               push_word = sha1md_pkg::PadMarkerWord;
               pend_in   = 1'b0;
            end else if (wib_ff == sha1md_pkg::LenHiSlot) begin
               push_word = len_ff[63:32];
               hi_in     = 1'b1;
            end else if (wib_ff == sha1md_pkg::BlockLastSlot && hi_ff) begin
               push_word = len_ff[31:0];
               done_in   = 1'b1;
            end
         end
         sha1md_pkg::ST_ROUND: begin
            v_in[4] = v_ff[3];
            v_in[3] = v_ff[2];
            v_in[2] = {v_ff[1][1:0], v_ff[1][31:2]};
            v_in[1] = v_ff[0];
            v_in[0] = t_val;
            for (int i = 0; i < sha1md_pkg::WindowDepth - 1; i++) begin
               win_in[i] = win_ff[i + 1];
            end
            win_in[sha1md_pkg::WindowDepth - 1] = w_next;
            rnd_in = rnd_ff + 7'd1;
            if (rnd_ff == sha1md_pkg::RoundLast) begin
               rnd_in   = '0;
               state_in = sha1md_pkg::ST_FINAL;
            end
         end
         sha1md_pkg::ST_FINAL: begin
            for (int i = 0; i < sha1md_pkg::NumHashWords; i++) begin
               h_in[i] = h_ff[i] + v_ff[i];
            end
            if (done_ff) begin
               state_in = sha1md_pkg::ST_OUT;
            end else if (pad_ff) begin
               state_in = sha1md_pkg::ST_PAD;
            end else begin
               state_in = sha1md_pkg::ST_IDLE;
            end
         end
         sha1md_pkg::ST_OUT: begin
            rsp_valid = 1'b1;
            if (!rsp_stall) begin
               oidx_in = oidx_ff + 3'd1;
               if (oidx_ff == sha1md_pkg::DigestLastIdx) begin
                  oidx_in  = '0;
                  h_in[0]  = sha1md_pkg::InitH0;
                  h_in[1]  = sha1md_pkg::InitH1;
                  h_in[2]  = sha1md_pkg::InitH2;
                  h_in[3]  = sha1md_pkg::InitH3;
                  h_in[4]  = sha1md_pkg::InitH4;
                  cnt_in   = '0;
                  wib_in   = '0;
                  pad_in   = 1'b0;
                  done_in  = 1'b0;
                  hi_in    = 1'b0;
                  state_in = sha1md_pkg::ST_IDLE;
               end
            end
         end
         default: begin
            state_in = sha1md_pkg::ST_IDLE;
         end
      endcase

      // advance the window on every pushed word; start a block when full
      if (push) begin
         for (int i = 0; i < sha1md_pkg::WindowDepth - 1; i++) begin
            win_in[i] = win_ff[i + 1];
         end
         win_in[sha1md_pkg::WindowDepth - 1] = push_word;
         wib_in = wib_ff + 4'd1;
         if (wib_ff == sha1md_pkg::BlockLastSlot) begin
            v_in     = h_ff;
            rnd_in   = '0;
            state_in = sha1md_pkg::ST_ROUND;
         end
      end
   end

   always_comb begin
      case (oidx_ff)
         3'd0:    rsp_digest_word = h_ff[0];
         3'd1:    rsp_digest_word = h_ff[1];
         3'd2:    rsp_digest_word = h_ff[2];
         3'd3:    rsp_digest_word = h_ff[3];
         default: rsp_digest_word = h_ff[4];
      endcase
      rsp_word_index = oidx_ff;
      rsp_last_word  = (oidx_ff == sha1md_pkg::DigestLastIdx);
   end

endmodule
